/* rtl/pfu_pkg.sv */
// shared types, constants and saturation helpers for the penalization force update core
// no dependencies
package pfu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int U31_W         = 31;
    localparam int CHI_W         = 17;
    localparam int IN_TDATA_W    = 344;
    localparam int OUT_TDATA_W   = 160;
    localparam int CFG_IDX_W     = 2;
    localparam int SAT_W         = 72;

    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TIME_STEP   = 2'd2;

    localparam logic [U31_W-1:0] U31_MAX = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRESS,
        ST_NXT,
        ST_MULF,
        ST_TV,
        ST_MULI,
        ST_UPD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } pfu_state_t;

    typedef struct packed {
        logic cap_in;
        logic en_press;
        logic en_nxt;
        logic en_mulf;
        logic en_tv;
        logic en_muli;
        logic en_upd;
        logic div_start;
        logic load_out;
    } pfu_cmd_t;

    typedef struct packed {
        logic last;
        logic div_busy;
        logic out_free;
    } pfu_sts_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = 72'sh0_0000_0000_7FFF_FFFF;
        lo = -72'sh0_0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[WORD_W-1:0];
    endfunction

    function automatic logic [U31_W-1:0] abs_sat31(input logic signed [32:0] v);
        logic signed [33:0] w;
        logic [33:0]        mag;
        w   = 34'(v);
        mag = (w < 0) ? 34'(-w) : 34'(w);
        if (mag > 34'(U31_MAX)) begin
            return U31_MAX;
        end
        return mag[U31_W-1:0];
    endfunction

endpackage

/* rtl/pfu_div.sv */
// restoring divider, one quotient bit per cycle, for the sweep error ratio
// depends on pfu_pkg
module pfu_div #(
    parameter int FRAC_BITS = pfu_pkg::FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [pfu_pkg::U31_W-1:0] numer,
    input  logic [pfu_pkg::U31_W-1:0] denom,
    output logic                     busy,
    output logic [pfu_pkg::U31_W-1:0] quot
);
    import pfu_pkg::*;

    localparam int DVD_W = U31_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [U31_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dq_reg, dq_next;
    logic [U31_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [U31_W:0]   trial;
    logic             qbit;

    always_comb begin
        trial = {rem_reg, dq_reg[DVD_W-1]};
        qbit  = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            dq_next   = {numer, FRAC_BITS'(0)};
            den_next  = denom;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = qbit ? U31_W'(trial - {1'b0, den_reg}) : trial[U31_W-1:0];
            dq_next   = {dq_reg[DVD_W-2:0], qbit};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = (|dq_reg[DVD_W-1:U31_W]) ? U31_MAX : dq_reg[U31_W-1:0];

endmodule

/* rtl/pfu_dp.sv */
// datapath: config registers, two axis lanes, running maxima, divider and output register
// depends on pfu_pkg and pfu_div
module pfu_dp #(
    parameter int FRAC_BITS = pfu_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pfu_pkg::pfu_cmd_t                cmd,
    output pfu_pkg::pfu_sts_t                sts,
    input  logic                             cfg_wr_en,
    input  logic [pfu_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [pfu_pkg::WORD_W-1:0]       cfg_wr_data,
    input  logic [pfu_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pfu_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);
    import pfu_pkg::*;

    localparam logic [WORD_W-1:0] ONE_Q = WORD_W'(1) << FRAC_BITS;

    logic signed [WORD_W-1:0] pf_reg;
    logic [U31_W-1:0]         ts_reg;
    logic [U31_W-1:0]         its_reg;

    logic signed [WORD_W-1:0] p_hi_reg  [2];
    logic signed [WORD_W-1:0] p_lo_reg  [2];
    logic signed [WORD_W-1:0] start_reg [2];
    logic signed [WORD_W-1:0] oldf_reg  [2];
    logic signed [WORD_W-1:0] body_reg  [2];
    logic [CHI_W-1:0]         chi_reg;
    logic                     last_reg;
    logic                     solid;

    logic signed [64:0]       prod_p_reg [2];
    logic signed [WORD_W-1:0] nxt_reg    [2];
    logic signed [63:0]       prod_v_reg [2];
    logic signed [50:0]       prod_c_reg [2];
    logic signed [WORD_W-1:0] vel_reg    [2];
    logic signed [32:0]       t_reg      [2];
    logic signed [64:0]       prod_f_reg [2];
    logic [U31_W-1:0]         spd_reg    [2];
    logic [U31_W-1:0]         err_reg    [2];
    logic signed [WORD_W-1:0] force_reg  [2];
    logic [U31_W-1:0]         max_spd_reg [2];
    logic [U31_W-1:0]         max_err_reg [2];

    logic [U31_W-1:0]       div_numer;
    logic [U31_W-1:0]       div_denom;
    logic [U31_W-1:0]       max_spd;
    logic                   div_busy;
    logic [U31_W-1:0]       div_quot;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pf_reg  <= '0;
            ts_reg  <= U31_W'(ONE_Q);
            its_reg <= U31_W'(ONE_Q);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_PRESSURE_FACTOR: pf_reg  <= cfg_wr_data;
                REG_TIME_STEP:       ts_reg  <= cfg_wr_data[U31_W-1:0];
                REG_INV_TIME_STEP:   its_reg <= cfg_wr_data[U31_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            p_hi_reg[0]  <= s_tdata[31:0];
            p_lo_reg[0]  <= s_tdata[63:32];
            p_hi_reg[1]  <= s_tdata[95:64];
            p_lo_reg[1]  <= s_tdata[127:96];
            start_reg[0] <= s_tdata[159:128];
            start_reg[1] <= s_tdata[191:160];
            oldf_reg[0]  <= s_tdata[223:192];
            oldf_reg[1]  <= s_tdata[255:224];
            body_reg[0]  <= s_tdata[287:256];
            body_reg[1]  <= s_tdata[319:288];
            chi_reg      <= s_tdata[336:320];
            last_reg     <= s_tlast;
        end
    end

    assign solid = WORD_W'(chi_reg) >= ONE_Q;

    for (genvar i = 0; i < 2; i++) begin : g_lane
        logic signed [32:0] p_diff;
        logic signed [32:0] b_minus_n;
        logic signed [32:0] b_minus_v;
        logic signed [50:0] t_sh;
        logic               t_fits;

        assign p_diff    = 33'(p_hi_reg[i]) - 33'(p_lo_reg[i]);
        assign b_minus_n = 33'(body_reg[i]) - 33'(nxt_reg[i]);
        assign b_minus_v = 33'(body_reg[i]) - 33'(vel_reg[i]);
        assign t_sh      = prod_c_reg[i] >>> FRAC_BITS;
        assign t_fits    = (&t_sh[50:32]) | ~(|t_sh[50:32]);

        always_ff @(posedge aclk) begin
            if (cmd.en_press) begin
                prod_p_reg[i] <= pf_reg * p_diff;
            end
            if (cmd.en_nxt) begin
                nxt_reg[i] <= sat32(SAT_W'(start_reg[i]) + SAT_W'(prod_p_reg[i] >>> FRAC_BITS));
            end
            if (cmd.en_mulf) begin
                prod_v_reg[i] <= $signed({1'b0, ts_reg}) * oldf_reg[i];
                prod_c_reg[i] <= $signed({1'b0, chi_reg}) * b_minus_n;
            end
            if (cmd.en_tv) begin
                vel_reg[i] <= sat32(SAT_W'(nxt_reg[i]) + SAT_W'(prod_v_reg[i] >>> FRAC_BITS));
                t_reg[i]   <= t_fits ? t_sh[32:0]
                                     : (t_sh[50] ? {1'b1, 32'h0} : {1'b0, 32'hFFFF_FFFF});
            end
            if (cmd.en_muli) begin
                prod_f_reg[i] <= t_reg[i] * $signed({1'b0, its_reg});
                spd_reg[i]    <= abs_sat31(33'(body_reg[i]));
                err_reg[i]    <= abs_sat31(b_minus_v);
            end
            if (cmd.en_upd) begin
                force_reg[i] <= sat32(SAT_W'(prod_f_reg[i] >>> FRAC_BITS));
            end
        end

        // running maxima over fully solid cells
        always_ff @(posedge aclk) begin
            if (!aresetn || cmd.div_start) begin
                max_spd_reg[i] <= '0;
                max_err_reg[i] <= '0;
            end else if (cmd.en_upd && solid) begin
                if (spd_reg[i] > max_spd_reg[i]) begin
                    max_spd_reg[i] <= spd_reg[i];
                end
                if (err_reg[i] > max_err_reg[i]) begin
                    max_err_reg[i] <= err_reg[i];
                end
            end
        end
    end

    assign div_numer = (max_err_reg[0] > max_err_reg[1]) ? max_err_reg[0] : max_err_reg[1];
    assign max_spd   = (max_spd_reg[0] > max_spd_reg[1]) ? max_spd_reg[0] : max_spd_reg[1];
    assign div_denom = (max_spd == '0) ? U31_W'(1) : max_spd;

    pfu_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            out_data_reg <= {1'b0, (last_reg ? div_quot : U31_W'(0)),
                             force_reg[1], force_reg[0], vel_reg[1], vel_reg[0]};
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign m_tlast      = out_last_reg;
    assign sts.last     = last_reg;
    assign sts.div_busy = div_busy;
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule

/* rtl/pfu_ctrl.sv */
// controller state machine sequencing one cell through the datapath
// depends on pfu_pkg
module pfu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pfu_pkg::pfu_sts_t sts,
    output pfu_pkg::pfu_cmd_t cmd
);
    import pfu_pkg::*;

    pfu_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PRESS;
                end
            end
            ST_PRESS:     state_next = ST_NXT;
            ST_NXT:       state_next = ST_MULF;
            ST_MULF:      state_next = ST_TV;
            ST_TV:        state_next = ST_MULI;
            ST_MULI:      state_next = ST_UPD;
            ST_UPD:       state_next = sts.last ? ST_DIV_START : ST_OUT;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (!sts.div_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.cap_in = s_tvalid;
            end
            ST_PRESS:     cmd.en_press  = 1'b1;
            ST_NXT:       cmd.en_nxt    = 1'b1;
            ST_MULF:      cmd.en_mulf   = 1'b1;
            ST_TV:        cmd.en_tv     = 1'b1;
            ST_MULI:      cmd.en_muli   = 1'b1;
            ST_UPD:       cmd.en_upd    = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_OUT:       cmd.load_out  = sts.out_free;
            default: ;
        endcase
    end

endmodule

/* rtl/penalization_force_update_with_error_core.sv */
// Penalization force update core, Q16.16 fixed point. A cell item is accepted while the
// controller is idle, and its result is loaded into the output register after a chain of
// seven registered steps, with at most two multiplies per lane in any step. A new cell is
// accepted only once the controller is back in idle. The last cell of a sweep also waits
// for the bit-serial divider that forms the error ratio. One cell is in work at a time.
// A finished result waits in the output register while the next cell is accepted, and that
// cell then holds at its last step until the output register is free. Config writes are
// taken on any cycle.
// Top level: instantiates pfu_ctrl and pfu_dp; depends on pfu_pkg.
module penalization_force_update_with_error_core #(
    parameter int FRAC_BITS = pfu_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pfu_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [pfu_pkg::WORD_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pressure_east, pressure_west, pressure_north, pressure_south, start_vel_x,
    // start_vel_y, old_force_x, old_force_y, body_vel_x, body_vel_y, solid_fraction
    input  logic [pfu_pkg::IN_TDATA_W-1:0]  s_tdata,
    // last_cell
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // new_vel_x, new_vel_y, new_force_x, new_force_y, relative_error
    output logic [pfu_pkg::OUT_TDATA_W-1:0] m_tdata,
    // sweep_done
    output logic                            m_tlast
);
    import pfu_pkg::*;

    pfu_cmd_t cmd;
    pfu_sts_t sts;

    pfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfu_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

/* bench/tb_penalization_force_update_with_error_core.sv */
// Self-checking bench for penalization_force_update_with_error_core: streams grid cells,
// predicts velocity, force and sweep error ratio in Q16.16, and compares every output item.
// Depends on pfu_pkg and the core RTL only.
module tb_penalization_force_update_with_error_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pfu_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 80;
    localparam int LONG_HOLD   = 500;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic [CHI_W-1:0] CHI_SOLID = 17'h1_0000;
    localparam logic [CHI_W-1:0] CHI_TOP   = 17'h1_FFFF;

    typedef logic signed [95:0] wide_t;

    localparam wide_t S32_HI = 96'sh7FFF_FFFF;
    localparam wide_t S32_LO = -96'sh8000_0000;
    localparam wide_t T33_HI = 96'shFFFF_FFFF;
    localparam wide_t T33_LO = -96'sh1_0000_0000;

    typedef struct {
        logic signed [WORD_W-1:0] p_east, p_west, p_north, p_south;
        logic signed [WORD_W-1:0] start_x, start_y, old_fx, old_fy, body_x, body_y;
        logic [CHI_W-1:0]         chi;
        logic                     last;
    } cell_t;

    typedef struct {
        logic signed [WORD_W-1:0] vel_x, vel_y, force_x, force_y;
        logic [U31_W-1:0]         rel;
        logic                     done;
    } update_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_wr_index = '0;
    logic [WORD_W-1:0]       cfg_wr_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // pressure_east, pressure_west, pressure_north, pressure_south, start_vel_x,
    // start_vel_y, old_force_x, old_force_y, body_vel_x, body_vel_y, solid_fraction
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    // last_cell
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // new_vel_x, new_vel_y, new_force_x, new_force_y, relative_error
    logic [OUT_TDATA_W-1:0]  m_tdata;
    // sweep_done
    logic                    m_tlast;

    // predictor copy of registers and running maxima
    logic signed [WORD_W-1:0] press_coef = '0;
    logic [U31_W-1:0]         dt_q = 31'h1_0000;
    logic [U31_W-1:0]         inv_dt_q = 31'h1_0000;
    logic [U31_W-1:0]         peak_speed_x = '0, peak_speed_y = '0;
    logic [U31_W-1:0]         peak_err_x = '0, peak_err_y = '0;

    update_t pending_updates[$];

    int errors = 0;
    int cells_sent = 0;
    int solid_cells = 0;
    int results_seen = 0;
    int sweeps_seen = 0;
    int settings_applied = 0;

    bit steady_sender = 1'b0;
    int burst_left = 1;

    rx_mode_t rx_mode = RX_OPEN;
    int rx_left = 0;
    int rx_tick = 0;
    int hold_left = 0;
    int hold_request = 0;

    penalization_force_update_with_error_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    always #6 aclk = ~aclk;

    function automatic wide_t clamp_s32(input wide_t v);
        if (v > S32_HI) begin
            return S32_HI;
        end else if (v < S32_LO) begin
            return S32_LO;
        end
        return v;
    endfunction

    function automatic logic [U31_W-1:0] mag31(input wide_t v);
        wide_t a;
        a = (v < 0) ? -v : v;
        return (a > wide_t'(U31_MAX)) ? U31_MAX : a[U31_W-1:0];
    endfunction

    task automatic axis_update(input logic signed [WORD_W-1:0] p_hi, p_lo, start, oldf, body,
                               input logic [CHI_W-1:0] chi, input bit solid,
                               output logic signed [WORD_W-1:0] vel, frc,
                               inout logic [U31_W-1:0] peak_speed, peak_err);
        wide_t corrected, v, t, f;
        logic [U31_W-1:0] spd, err;
        corrected = clamp_s32(wide_t'(start)
                    + ((wide_t'(press_coef) * (wide_t'(p_hi) - wide_t'(p_lo))) >>> FRAC));
        v = clamp_s32(corrected + ((wide_t'(dt_q) * wide_t'(oldf)) >>> FRAC));
        t = (wide_t'(chi) * (wide_t'(body) - corrected)) >>> FRAC;
        if (t > T33_HI) t = T33_HI;
        if (t < T33_LO) t = T33_LO;
        f = clamp_s32((t * wide_t'(inv_dt_q)) >>> FRAC);
        vel = v[WORD_W-1:0];
        frc = f[WORD_W-1:0];
        if (solid) begin
            spd = mag31(wide_t'(body));
            err = mag31(wide_t'(body) - v);
            if (spd > peak_speed) peak_speed = spd;
            if (err > peak_err) peak_err = err;
        end
    endtask

    task automatic predict_cell(input cell_t c, output update_t u);
        bit solid;
        logic [U31_W-1:0] err_top, spd_top;
        logic [63:0] ratio;
        solid = (c.chi >= CHI_SOLID);
        if (solid) solid_cells++;
        axis_update(c.p_east, c.p_west, c.start_x, c.old_fx, c.body_x, c.chi, solid,
                    u.vel_x, u.force_x, peak_speed_x, peak_err_x);
        axis_update(c.p_north, c.p_south, c.start_y, c.old_fy, c.body_y, c.chi, solid,
                    u.vel_y, u.force_y, peak_speed_y, peak_err_y);
        u.rel = '0;
        u.done = c.last;
        if (c.last) begin
            err_top = (peak_err_x > peak_err_y) ? peak_err_x : peak_err_y;
            spd_top = (peak_speed_x > peak_speed_y) ? peak_speed_x : peak_speed_y;
            if (spd_top == 0) spd_top = U31_W'(1);
            ratio = (64'(err_top) << FRAC) / 64'(spd_top);
            u.rel = (ratio > 64'(U31_MAX)) ? U31_MAX : ratio[U31_W-1:0];
            peak_speed_x = '0;
            peak_speed_y = '0;
            peak_err_x = '0;
            peak_err_y = '0;
        end
    endtask

    task automatic send_cell(input cell_t c);
        update_t u;
        s_tdata = {7'b0, c.chi, c.body_y, c.body_x, c.old_fy, c.old_fx, c.start_y, c.start_x,
                   c.p_south, c.p_north, c.p_west, c.p_east};
        s_tlast = c.last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_cell(c, u);
        pending_updates.push_back(u);
        cells_sent++;
        @(negedge aclk);
        if (!steady_sender) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_updates.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_PRESSURE_FACTOR: press_coef = data;
            REG_TIME_STEP:       dt_q = data[U31_W-1:0];
            REG_INV_TIME_STEP:   inv_dt_q = data[U31_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [WORD_W-1:0] pf, ts, its);
        drain();
        cfg_write(REG_PRESSURE_FACTOR, pf);
        cfg_write(REG_TIME_STEP, ts);
        cfg_write(REG_INV_TIME_STEP, its);
        settings_applied++;
    endtask

    function automatic cell_t flat_cell(input logic signed [WORD_W-1:0] v,
                                        input logic [CHI_W-1:0] chi, input logic last);
        cell_t c;
        c.p_east = v;  c.p_west = v;  c.p_north = v; c.p_south = v;
        c.start_x = v; c.start_y = v; c.old_fx = v;  c.old_fy = v;
        c.body_x = v;  c.body_y = v;
        c.chi = chi;
        c.last = last;
        return c;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_q();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
            return $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
        end else if (pick < 19) begin
            return $urandom();
        end
        case ($urandom_range(0, 4))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic logic [CHI_W-1:0] rand_chi();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return CHI_SOLID;
        end else if (pick < 6) begin
            return '0;
        end else if (pick < 9) begin
            return CHI_W'($urandom_range(0, 32'h1_0000));
        end
        return CHI_W'($urandom_range(32'h1_0001, 32'h1_FFFF));
    endfunction

    function automatic cell_t random_cell(input logic last);
        cell_t c;
        c.p_east = rand_q();  c.p_west = rand_q();  c.p_north = rand_q(); c.p_south = rand_q();
        c.start_x = rand_q(); c.start_y = rand_q(); c.old_fx = rand_q();  c.old_fy = rand_q();
        c.body_x = rand_q();  c.body_y = rand_q();
        c.chi = rand_chi();
        c.last = last;
        return c;
    endfunction

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        update_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_updates.pop_front();
                compare_field("new_vel_x", want.vel_x, m_tdata[31:0]);
                compare_field("new_vel_y", want.vel_y, m_tdata[63:32]);
                compare_field("new_force_x", want.force_x, m_tdata[95:64]);
                compare_field("new_force_y", want.force_y, m_tdata[127:96]);
                compare_field("relative_error", 32'(want.rel), 32'(m_tdata[158:128]));
                compare_field("sweep_done", 32'(want.done), 32'(m_tlast));
                results_seen++;
                if (m_tlast) sweeps_seen++;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_left = $urandom_range(40, 300);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN: m_tready = 1'b1;
                RX_COIN: m_tready = 1'($urandom_range(0, 1));
                default: m_tready = (rx_tick % 5 == 0);
            endcase
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // reset register values, zero and saturated fields
    task automatic test_reset_defaults();
        cell_t c;
        send_cell(flat_cell(32'sd0, '0, 1'b0));
        send_cell(flat_cell(Q_MAX, CHI_SOLID, 1'b0));
        send_cell(flat_cell(Q_MIN, CHI_TOP, 1'b0));
        c = flat_cell(Q_ONE, 17'h0_8000, 1'b1);
        c.p_east = 32'sh0002_0000;
        c.body_y = -32'sh0003_0000;
        send_cell(c);
    endtask

    task automatic test_directed_corners();
        cell_t c;
        apply_settings(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        c = flat_cell(Q_MAX, CHI_SOLID, 1'b0);
        c.p_west = Q_MIN;  c.p_north = Q_MIN;
        c.start_y = Q_MIN; c.old_fy = Q_MIN; c.body_x = Q_MIN;
        send_cell(c);
        send_cell(flat_cell(Q_MIN, CHI_TOP, 1'b1));
        apply_settings(32'h0, 32'h1_0000, 32'h1_0000);
        // zero body speed with an error: divisor of one lsb, ratio saturates
        c = flat_cell(32'sd0, CHI_SOLID, 1'b1);
        c.start_x = 32'sh0005_0000;
        send_cell(c);
        // zero speed and zero error
        send_cell(flat_cell(32'sd0, CHI_SOLID, 1'b1));
        // just below fully solid: maxima stay clear
        c = flat_cell(32'sd0, 17'h0_FFFF, 1'b1);
        c.body_x = 32'sh0040_0000;
        send_cell(c);
        c = flat_cell(32'sd0, CHI_SOLID, 1'b0);
        c.start_x = Q_ONE;
        c.body_x = 32'sh0003_0000;
        send_cell(c);
        c = flat_cell(32'sd0, CHI_SOLID, 1'b1);
        c.body_y = -32'sh0004_0000;
        c.old_fy = 32'sh0000_8000;
        send_cell(c);
    endtask

    // writes to the unused index must leave every register alone
    task automatic test_spare_register();
        cell_t c;
        apply_settings(32'hFFFF_8000, 32'h0000_4000, 32'h0004_0000);
        drain();
        cfg_write(REG_SPARE, $urandom());
        repeat (2) send_cell(random_cell(1'b0));
        c = random_cell(1'b1);
        c.chi = CHI_SOLID;
        send_cell(c);
    endtask

    task automatic test_random_sweeps(input logic [WORD_W-1:0] pf, ts, its, input int n_cells);
        int sent, len, i;
        apply_settings(pf, ts, its);
        steady_sender = ($urandom_range(0, 3) == 0);
        sent = 0;
        while (sent < n_cells) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            for (i = 0; i < len; i++) begin
                send_cell(random_cell(i == len - 1));
                if ($urandom_range(0, 149) == 0) drain();
            end
            sent += len;
        end
        steady_sender = 1'b0;
    endtask

    // receiver holds off while cells keep coming, so the core backs up its input
    task automatic test_output_backpressure();
        int i;
        drain();
        steady_sender = 1'b1;
        hold_request = LONG_HOLD;
        for (i = 0; i < 24; i++) begin
            send_cell(random_cell(i == 23));
        end
        steady_sender = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_directed_corners();
        test_spare_register();
        test_random_sweeps(-32'sd20972, 32'd655, 32'd6553600, 300);
        test_output_backpressure();
        test_random_sweeps(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 250);
        test_random_sweeps(32'h7FFF_FFFF, 32'h0, 32'h0, 250);
        test_random_sweeps($urandom(), $urandom(), $urandom(), 300);
        test_random_sweeps(-32'sd32768, 32'h1_0000, 32'h1_0000, 300);
        test_random_sweeps($urandom_range(0, 32'h3_0000) - 32'h1_8000,
                           {1'($urandom_range(0, 1)),
                            31'(32'h1_0000 >> $urandom_range(0, 8))},
                           {1'($urandom_range(0, 1)),
                            31'($urandom_range(32'h1_0000, 32'h40_0000))},
                           350);
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("run covered %0d cells (%0d fully solid) over %0d register settings",
                 cells_sent, solid_cells, settings_applied);
        $display("checked %0d output items, %0d of them closing a sweep, %0d errors",
                 results_seen, sweeps_seen, errors);
        if (errors == 0 && pending_updates.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
